// File: design/tk_pkg.sv
// Shared constants, token type and helpers for the top-K tracker.
package tk_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned K_W    = $clog2(DEPTH + 1);
  localparam int unsigned KC_W   = 7;   // keep_count register width
  localparam int unsigned RANK_W = 6;

  localparam logic [KC_W-1:0] KC_RESET = KC_W'(64);

  typedef enum logic [1:0] {
    TK_NOP    = 2'd0,
    TK_OFFER  = 2'd1,
    TK_READ   = 2'd2,
    TK_RESULT = 2'd3
  } tok_kind_e;

  // Token that walks down the cell chain, one cell per cycle while the chain is not frozen.
  typedef struct packed {
    logic                    valid;
    tok_kind_e               kind;
    logic                    acc;
    logic signed [VAL_W-1:0] carry;
    logic [IDX_W-1:0]        target;
  } tok_t;

  // Clamp keep_count into 1..DEPTH.
  function automatic logic [K_W-1:0] clamp_k(input logic [KC_W-1:0] kc);
    logic [K_W-1:0] k;
    if (kc == '0) begin
      k = K_W'(1);
    end else if (32'(kc) > DEPTH) begin
      k = K_W'(DEPTH);
    end else begin
      k = K_W'(kc);
    end
    return k;
  endfunction

endpackage

// File: design/tk_cell.sv
// One entry of the sorted store plus the token stage that follows it.
module tk_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic [tk_pkg::IDX_W-1:0]            cell_idx_i,
  input  logic [tk_pkg::IDX_W-1:0]            last_idx_i,
  input  logic signed [tk_pkg::VAL_W-1:0]     nxt_val_i,
  input  tk_pkg::tok_t                        tok_i,
  output logic signed [tk_pkg::VAL_W-1:0]     val_o,
  output tk_pkg::tok_t                        tok_o
);

  logic signed [tk_pkg::VAL_W-1:0] val_q, val_d;
  tk_pkg::tok_t                    tok_q, tok_d;

  always_comb begin
    val_d = val_q;
    tok_d = tok_i;
    if (tok_i.valid) begin
      case (tok_i.kind)
        tk_pkg::TK_OFFER: begin
          if (cell_idx_i == last_idx_i) begin
            val_d      = tok_i.carry;
            tok_d.kind = tk_pkg::TK_NOP;
          end else if (tok_i.carry > nxt_val_i) begin
            // carried value keeps sinking, neighbor moves down
            val_d = nxt_val_i;
          end else begin
            val_d       = tok_i.carry;
            tok_d.carry = nxt_val_i;
          end
        end
        tk_pkg::TK_READ: begin
          if (cell_idx_i == tok_i.target) begin
            tok_d.carry = val_q;
            tok_d.kind  = tk_pkg::TK_RESULT;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      tok_q <= '0;
    end else if (en_i) begin
      val_q <= val_d;
      tok_q <= tok_d;
    end
  end

  assign val_o = val_q;
  assign tok_o = tok_q;

endmodule

// File: design/top_k_sorted_tracker.sv
// Top level of the streaming top-K tracker: entry stage, cell chain, output register.
//
// Keeps the K largest signed values offered so far, sorted ascending across a
// row of DEPTH cells. Input stream: tuser = mode (0 offer, 1 read), tdata =
// value_in [31:0], rank [37:32]. Output stream: tuser = accepted, tdata =
// value_out. Every input transfer yields exactly one output transfer.
// An offer larger than the current minimum replaces it; a token then walks
// the chain one cell per cycle unless the chain is frozen, each cell doing
// one compare-and-swap against its upper neighbor. A read token walks the
// same chain and picks up the entry at rank counted from the largest.
// The token goes from the entry register down the whole chain of DEPTH cells
// into the output register. One item is in flight at a time, so the next
// item is taken once the previous result sits in the output register.
// Reset clears every entry to zero and keep_count to 64. If the receiver
// stalls with a result pending and a second result reaches the chain end,
// the whole chain freezes until the output register frees up.
// cfg_we_i writes keep_count; write it only while the block is idle.
module top_k_sorted_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,     // keep_count
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // [31:0] value_in, [37:32] rank, [39:38] zero
  input  logic        s_axis_tuser_i,  // [0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [31:0] value_out
  output logic        m_axis_tuser_o   // [0] accepted
);

  localparam int unsigned N = tk_pkg::DEPTH;

  logic [tk_pkg::K_W-1:0]              k_q;
  logic [tk_pkg::K_W-1:0]              k_m1;
  logic [tk_pkg::IDX_W-1:0]            last_idx;
  logic                                busy_q;
  logic                                en;
  logic                                s_xfer;
  tk_pkg::tok_t                        tok0_q;
  tk_pkg::tok_t                        tok_new;
  tk_pkg::tok_t                        tok_end;
  tk_pkg::tok_t                        toks   [N];
  logic signed [tk_pkg::VAL_W-1:0]     vals   [N];
  logic signed [tk_pkg::VAL_W-1:0]     value_in;
  logic [tk_pkg::RANK_W-1:0]           rank;
  logic [31:0]                         tgt_w;
  logic                                out_vld_q;
  logic                                out_acc_q;
  logic [31:0]                         out_val_q;

  assign value_in = s_axis_tdata_i[31:0];
  assign rank     = s_axis_tdata_i[37:32];
  assign k_m1     = k_q - tk_pkg::K_W'(1);
  assign last_idx = k_m1[tk_pkg::IDX_W-1:0];
  assign tgt_w    = 32'(k_q) - 32'd1 - 32'(rank);
  assign tok_end  = toks[N-1];

  assign s_axis_tready_o = !busy_q;
  assign s_xfer          = s_axis_tvalid_i && !busy_q;
  // freeze the chain only when a result arrives at a full, stalled output
  assign en = !(tok_end.valid && out_vld_q && !m_axis_tready_i);

  always_comb begin
    tok_new        = '0;
    tok_new.valid  = 1'b1;
    tok_new.target = tgt_w[tk_pkg::IDX_W-1:0];
    if (!s_axis_tuser_i) begin
      tok_new.carry = value_in;
      tok_new.acc   = value_in > vals[0];
      tok_new.kind  = tok_new.acc ? tk_pkg::TK_OFFER : tk_pkg::TK_NOP;
    end else if (32'(rank) < 32'(k_q)) begin
      tok_new.kind = tk_pkg::TK_READ;
    end else begin
      tok_new.kind = tk_pkg::TK_RESULT;  // out-of-range rank reads as zero
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= tk_pkg::clamp_k(tk_pkg::KC_RESET);
      busy_q <= 1'b0;
      tok0_q <= '0;
    end else begin
      if (cfg_we_i) begin
        k_q <= tk_pkg::clamp_k(cfg_wdata_i);
      end
      if (s_xfer) begin
        tok0_q <= tok_new;
        busy_q <= 1'b1;
      end else begin
        if (en) begin
          tok0_q.valid <= 1'b0;
        end
        if (tok_end.valid && en) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic signed [tk_pkg::VAL_W-1:0] nxt;
    if (g < N - 1) begin : g_mid
      assign nxt = vals[g+1];
    end else begin : g_end
      assign nxt = '0;
    end
    tk_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .cell_idx_i (tk_pkg::IDX_W'(g)),
      .last_idx_i (last_idx),
      .nxt_val_i  (nxt),
      .tok_i      ((g == 0) ? tok0_q : toks[(g == 0) ? 0 : g-1]),
      .val_o      (vals[g]),
      .tok_o      (toks[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (tok_end.valid && en) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_end.valid && en) begin
      out_acc_q <= tok_end.acc;
      out_val_q <= (tok_end.kind == tk_pkg::TK_RESULT) ? tok_end.carry : '0;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_val_q;
  assign m_axis_tuser_o  = out_acc_q;

endmodule

// File: design/tk_checker.sv
// Port-level checks for the top-K tracker, bound to the top level.
module tk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  logic s_xfer;
  assign s_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // one item in flight: no transfer right after another
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !s_axis_tready_o)
    else $error("input taken while an item is in flight");

  // an accepted offer reports no value
  a_offer_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 32'd0)
    else $error("accepted result carries a nonzero value");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output payload changed while stalled");

endmodule

bind top_k_sorted_tracker tk_checker u_tk_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// File: tb/top_k_tb_pkg.sv
// Result type and scoreboard with the top-K predictor for the tracker testbench.
package top_k_tb_pkg;

  localparam bit MODE_OFFER = 1'b0;
  localparam bit MODE_READ  = 1'b1;

  typedef struct packed {
    logic                accepted;
    logic signed [31:0]  value_out;
  } tk_result_t;

  class top_k_scoreboard;
    logic signed [31:0]      kept [tk_pkg::DEPTH];
    logic [tk_pkg::KC_W-1:0] keep_count;
    tk_result_t              due_results [$];
    int unsigned             failures;

    function new();
      foreach (kept[i]) kept[i] = '0;
      keep_count = tk_pkg::KC_RESET;
      failures   = 0;
    endfunction

    function void set_keep_count(logic [tk_pkg::KC_W-1:0] kc);
      keep_count = kc;
    endfunction

    // keep_count clamped into 1..DEPTH
    function int unsigned kept_k();
      int unsigned k;
      k = keep_count;
      if (k == 0) begin
        k = 1;
      end else if (k > tk_pkg::DEPTH) begin
        k = tk_pkg::DEPTH;
      end
      return k;
    endfunction

    function logic signed [31:0] smallest();
      return kept[0];
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function void note_item(bit mode, logic signed [31:0] value, logic [5:0] rank);
      tk_result_t         r;
      int unsigned        k;
      logic signed [31:0] t;
      r = '0;
      k = kept_k();
      if (mode == MODE_OFFER) begin
        if (value > kept[0]) begin
          kept[0] = value;
          // one bubble pass sinks the new value to its place
          for (int unsigned i = 0; i + 1 < k; i++) begin
            if (kept[i] > kept[i+1]) begin
              t         = kept[i];
              kept[i]   = kept[i+1];
              kept[i+1] = t;
            end
          end
          r.accepted = 1'b1;
        end
      end else if (rank < k) begin
        r.value_out = kept[k - 1 - rank];
      end
      due_results.push_back(r);
    endfunction

    function void check_result(logic accepted, logic signed [31:0] value_out);
      tk_result_t e;
      if (due_results.size() == 0) begin
        $error("result with none expected: accepted %0d value_out %0d", accepted, value_out);
        failures++;
        return;
      end
      e = due_results.pop_front();
      if (accepted !== e.accepted) begin
        $error("accepted: expected %0d, actual %0d", e.accepted, accepted);
        failures++;
      end
      if (value_out !== e.value_out) begin
        $error("value_out: expected %0d, actual %0d", e.value_out, value_out);
        failures++;
      end
    endfunction
  endclass

endpackage

// File: tb/tb.sv
// Testbench top for the streaming top-K tracker: stimulus, stalls and result checking.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import top_k_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned ITEMS_PER_PH = 144;
  localparam int unsigned SETTLE       = tk_pkg::DEPTH + 4;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  logic        s_valid;
  logic        s_ready;
  logic [39:0] s_data;   // [31:0] value_in, [37:32] rank, [39:38] zero
  logic        s_user;   // [0] mode
  logic        m_valid;
  logic        m_ready;
  logic [31:0] m_data;   // [31:0] value_out
  logic        m_user;   // [0] accepted

  bit          no_idle;
  bit          hold_req;
  int unsigned cycle_count;

  top_k_scoreboard sb;

  top_k_sorted_tracker u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(bit mode, logic signed [31:0] value, logic [5:0] rank);
    if (!no_idle && $urandom_range(99) < 31) begin
      s_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_user  = mode;
    s_data  = {2'b00, rank, value};
    do @(posedge clk_i); while (!s_ready);
    sb.note_item(mode, value, rank);
    @(negedge clk_i);
  endtask

  // Drain all results, let the chain settle, then write keep_count.
  task automatic write_keep(logic [6:0] kc);
    s_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = kc;
    @(negedge clk_i);
    cfg_we = 1'b0;
    sb.set_keep_count(kc);
  endtask

  task automatic send_random_item();
    int unsigned        pick;
    int unsigned        k;
    logic signed [31:0] v;
    logic [5:0]         r;
    pick = $urandom_range(99);
    k    = sb.kept_k();
    v    = $urandom;
    r    = $urandom_range(63);
    if (pick < 25) begin
      // reads: bias toward the last valid rank and the first one past it
      case ($urandom_range(3))
        0: r = 6'(k - 1);
        1: if (k < 64) r = 6'(k);
        default: ;
      endcase
      send_item(MODE_READ, v, r);
    end else begin
      if (pick < 45) begin
        v = $urandom_range(1, 1000);
      end else if (pick < 62) begin
        v = sb.smallest() + $signed($urandom_range(2)) - 1;  // just below, at, just above the minimum
      end else if (pick < 70) begin
        case ($urandom_range(4))
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end else if (pick < 85) begin
        v = v & 32'sh7fffffff;
      end
      send_item(MODE_OFFER, v, r);
    end
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_ready = no_idle ? 1'b1 : ($urandom_range(99) >= 31);
      end
    end
  end

  // result monitor
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_valid && m_ready) sb.check_result(m_user, $signed(m_data));
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [6:0] phase_keep [8];
    phase_keep = '{7'd2, 7'd64, 7'd5, 7'd1, 7'd33, 7'd127, 7'd0, 7'd64};
    sb        = new();
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_valid   = 1'b0;
    s_data    = '0;
    s_user    = MODE_OFFER;
    m_ready   = 1'b0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset contents, non-positive offers, extremes
    send_item(MODE_READ,  32'sh5a5a5a5a, 6'd0);
    send_item(MODE_READ,  32'sh0,        6'd63);
    send_item(MODE_OFFER, 32'sh0,        6'd63);
    send_item(MODE_OFFER, -1,            6'd0);
    send_item(MODE_OFFER, 32'sh80000000, 6'd21);
    send_item(MODE_OFFER, 32'sh7fffffff, 6'd42);
    send_item(MODE_OFFER, 32'sh1,        6'd0);
    send_item(MODE_READ,  -1,            6'd0);
    send_item(MODE_READ,  32'sh0,        6'd1);
    send_item(MODE_READ,  32'sh0,        6'd63);
    // K of one: equal value is refused, rank past K reads zero
    write_keep(7'd1);
    send_item(MODE_OFFER, 32'sh5,        6'd0);
    send_item(MODE_OFFER, 32'sh5,        6'd0);
    send_item(MODE_OFFER, 32'sh6,        6'd0);
    send_item(MODE_READ,  32'sh0,        6'd0);
    send_item(MODE_READ,  32'sh0,        6'd1);
    // zero acts as one, above DEPTH acts as DEPTH
    write_keep(7'd0);
    send_item(MODE_OFFER, 32'sh3,        6'd0);
    send_item(MODE_READ,  32'sh0,        6'd0);
    write_keep(7'd127);
    send_item(MODE_READ,  32'sh0,        6'd63);
    send_item(MODE_OFFER, 32'sh2,        6'd0);
    send_item(MODE_READ,  32'sh0,        6'd0);

    foreach (phase_keep[p]) begin
      write_keep(phase_keep[p]);
      no_idle = (p == 3);
      for (int n = 0; n < ITEMS_PER_PH; n++) begin
        if (p == 1 && n == 20) hold_req = 1'b1;
        send_random_item();
      end
    end
    s_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: top_k_sorted_tracker.f
design/tk_pkg.sv
design/tk_cell.sv
design/top_k_sorted_tracker.sv
design/tk_checker.sv
tb/top_k_tb_pkg.sv
tb/tb.sv
